[design/sira_pkg.sv]
// ----------------------------------------------------------------------------
// sira_pkg
// Shared constants and the CORDIC arctangent table for the segment crossing
// block.
// ----------------------------------------------------------------------------
package sira_pkg;

  localparam int          NORM_BIT    = 51;   // larger component lands in [2^51, 2^52)
  localparam int          CORDIC_W    = 56;   // CORDIC x/y datapath width
  localparam int          SHIFT_W     = 6;    // normalize shift amount width
  localparam int          SQRT_STEPS  = 32;   // root bits of a 64-bit radicand
  localparam int          ATAN_LEN    = 24;
  localparam logic [31:0] ANG_HALF    = 32'h8000_0000;
  localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
  localparam logic [15:0] DEG_SCALE   = 16'd23040;  // 90 degrees in 1/256 degree
  localparam logic [47:0] ANG_ROUND   = 48'h0000_2000_0000;
  localparam logic [31:0] OUT_MAX     = 32'hFFFF_FFFF;
  localparam logic [15:0] LIMIT_RESET = 16'd1;

  // atan(2^-i) as a fraction of a full turn (2^32)
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      20:      r = 32'd652;
      21:      r = 32'd326;
      22:      r = 32'd163;
      23:      r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[design/sira_in_if.sv]
// ----------------------------------------------------------------------------
// sira_in_if
// Input channel: two segments per transfer, signed Q16.16 endpoints.
// ----------------------------------------------------------------------------
interface sira_in_if #(parameter int CoordWidth = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] p_start_x;
  logic signed [CoordWidth-1:0] p_start_y;
  logic signed [CoordWidth-1:0] p_end_x;
  logic signed [CoordWidth-1:0] p_end_y;
  logic signed [CoordWidth-1:0] q_start_x;
  logic signed [CoordWidth-1:0] q_start_y;
  logic signed [CoordWidth-1:0] q_end_x;
  logic signed [CoordWidth-1:0] q_end_y;

  modport source (output valid, p_start_x, p_start_y, p_end_x, p_end_y,
                  q_start_x, q_start_y, q_end_x, q_end_y, input ready);
  modport sink   (input valid, p_start_x, p_start_y, p_end_x, p_end_y,
                  q_start_x, q_start_y, q_end_x, q_end_y, output ready);
endinterface

[design/sira_out_if.sv]
// ----------------------------------------------------------------------------
// sira_out_if
// Result channel: hit flag, crossing point, range and incidence angle.
// ----------------------------------------------------------------------------
interface sira_out_if ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic        [31:0] range;
  logic        [14:0] incidence;

  modport source (output valid, hit, hit_x, hit_y, range, incidence, input ready);
  modport sink   (input valid, hit, hit_x, hit_y, range, incidence, output ready);
endinterface

[design/sira_delay.sv]
// ----------------------------------------------------------------------------
// sira_delay
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module sira_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  if (Depth == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [Width-1:0] line_q [Depth];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        line_q[0] <= d_i;
        for (int k = 1; k < Depth; k++) line_q[k] <= line_q[k-1];
      end
    end
    assign q_o = line_q[Depth-1];
  end

endmodule

[design/sira_mul.sv]
// ----------------------------------------------------------------------------
// sira_mul
// Two-stage signed multiplier: b is split in halves, partial products are
// registered, then summed.
// ----------------------------------------------------------------------------
module sira_mul #(
  parameter int AWidth = 33,
  parameter int BWidth = 33
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [AWidth-1:0]        a_i,
  input  logic signed [BWidth-1:0]        b_i,
  output logic signed [AWidth+BWidth-1:0] p_o
);

  localparam int Lo = BWidth / 2;
  localparam int Hi = BWidth - Lo;
  localparam int PW = AWidth + BWidth;

  logic signed [AWidth+Lo:0]   lo_q;
  logic signed [AWidth+Hi-1:0] hi_q;
  logic signed [PW-1:0]        p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= a_i * $signed({1'b0, b_i[Lo-1:0]});
      hi_q <= a_i * $signed(b_i[BWidth-1:Lo]);
      p_q  <= PW'(lo_q) + (PW'(hi_q) <<< Lo);
    end
  end

  assign p_o = p_q;

endmodule

[design/sira_div.sv]
// ----------------------------------------------------------------------------
// sira_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The numerator must be below den << QuoWidth.
// ----------------------------------------------------------------------------
module sira_div #(
  parameter int NumWidth = 102,
  parameter int DenWidth = 68,
  parameter int QuoWidth = 33
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  input  logic                tag_i,
  output logic [QuoWidth-1:0] quo_o,
  output logic                tag_o
);

  logic [NumWidth-1:0] rem_q [QuoWidth];
  logic [DenWidth-1:0] den_q [QuoWidth];
  logic [QuoWidth-1:0] quo_q [QuoWidth];
  logic                tag_q [QuoWidth];

  for (genvar j = 0; j < QuoWidth; j++) begin : g_step
    localparam int K = QuoWidth - 1 - j;
    logic [NumWidth-1:0] r_in, trial;
    logic [DenWidth-1:0] d_in;
    logic [QuoWidth-1:0] q_in;
    logic                t_in, ge;

    if (j == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
      assign t_in = tag_q[j-1];
    end

    assign trial = NumWidth'(d_in) << K;
    assign ge    = (r_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? r_in - trial : r_in;
        den_q[j] <= d_in;
        quo_q[j] <= q_in | (QuoWidth'(ge) << K);
        tag_q[j] <= t_in;
      end
    end
  end

  assign quo_o = quo_q[QuoWidth-1];
  assign tag_o = tag_q[QuoWidth-1];

endmodule

[design/sira_heading.sv]
// ----------------------------------------------------------------------------
// sira_heading
// Binary angle of a vector: magnitude and null check, normalize, half-turn
// fold, then one CORDIC vectoring step per stage.
// ----------------------------------------------------------------------------
module sira_heading
  import sira_pkg::*;
#(
  parameter int Width = 35,
  parameter int Steps = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [15:0]             limit_i,
  input  logic signed [Width-1:0] x_i,
  input  logic signed [Width-1:0] y_i,
  output logic [31:0]             z_o
);

  // stage 1: magnitudes
  logic [Width-1:0] ux_d, uy_d, ux_q, uy_q, m_q, ux2_q, uy2_q;
  logic             sx_q, sy_q, nul_q, sx2_q, sy2_q, nul2_q;
  logic [SHIFT_W-1:0] s_q;
  logic [SHIFT_W-1:0] pos;

  assign ux_d = x_i[Width-1] ? Width'(-x_i) : Width'(x_i);
  assign uy_d = y_i[Width-1] ? Width'(-y_i) : Width'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q  <= ux_d;
      uy_q  <= uy_d;
      m_q   <= (ux_d > uy_d) ? ux_d : uy_d;
      sx_q  <= x_i[Width-1];
      sy_q  <= y_i[Width-1];
      nul_q <= ((ux_d < Width'(limit_i)) && (uy_d < Width'(limit_i))) ||
               ((ux_d == '0) && (uy_d == '0));
    end
  end

  // stage 2: leading one of the larger component
  always_comb begin
    pos = '0;
    for (int k = 0; k < Width; k++) if (m_q[k]) pos = SHIFT_W'(k);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux2_q  <= ux_q;
      uy2_q  <= uy_q;
      sx2_q  <= sx_q;
      sy2_q  <= sy_q;
      nul2_q <= nul_q;
      s_q    <= SHIFT_W'(NORM_BIT) - pos;
    end
  end

  // stage 3: shift and half-turn fold (x lands nonnegative)
  logic signed [CORDIC_W-1:0] cx0_q, cy0_q, ymag;
  logic [31:0]                z0_q;
  logic                       nul3_q;

  assign ymag = $signed(CORDIC_W'(uy2_q) << s_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx0_q  <= $signed(CORDIC_W'(ux2_q) << s_q);
      cy0_q  <= (sx2_q ^ sy2_q) ? -ymag : ymag;
      z0_q   <= sx2_q ? ANG_HALF : 32'd0;
      nul3_q <= nul2_q;
    end
  end

  // CORDIC vectoring
  logic signed [CORDIC_W-1:0] cx_q [Steps];
  logic signed [CORDIC_W-1:0] cy_q [Steps];
  logic [31:0]                z_q  [Steps];
  logic                       n_q  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] cx_in, cy_in, xs, ys;
    logic [31:0]                z_in;
    logic                       n_in;

    if (i == 0) begin : g_first
      assign cx_in = cx0_q;
      assign cy_in = cy0_q;
      assign z_in  = z0_q;
      assign n_in  = nul3_q;
    end else begin : g_next
      assign cx_in = cx_q[i-1];
      assign cy_in = cy_q[i-1];
      assign z_in  = z_q[i-1];
      assign n_in  = n_q[i-1];
    end

    assign xs = cx_in >>> i;
    assign ys = cy_in >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_in[CORDIC_W-1]) begin
          cx_q[i] <= cx_in + ys;
          cy_q[i] <= cy_in - xs;
          z_q[i]  <= z_in + atan_turn(i);
        end else begin
          cx_q[i] <= cx_in - ys;
          cy_q[i] <= cy_in + xs;
          z_q[i]  <= z_in - atan_turn(i);
        end
        n_q[i] <= n_in;
      end
    end
  end

  assign z_o = n_q[Steps-1] ? 32'd0 : z_q[Steps-1];

endmodule

[design/sira_range.sv]
// ----------------------------------------------------------------------------
// sira_range
// Euclidean length of the offset: squares, sum with overflow check, then a
// digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sira_range
  import sira_pkg::*;
#(
  parameter int Width = 34
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [Width-1:0] ox_i,
  input  logic signed [Width-1:0] oy_i,
  output logic [31:0]             root_o,
  output logic [33:0]             rem_o,
  output logic                    sat_o
);

  localparam int UW = (Width > 33) ? Width : 33;

  logic [UW-1:0] ux, uy;
  logic [63:0]   sx_q, sy_q, sq_q;
  logic          sat1_q, sat2_q;
  logic [64:0]   sum;

  assign ux = ox_i[Width-1] ? UW'(-ox_i) : UW'(ox_i);
  assign uy = oy_i[Width-1] ? UW'(-oy_i) : UW'(oy_i);
  assign sum = {1'b0, sx_q} + {1'b0, sy_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q   <= 64'(ux[31:0]) * 64'(ux[31:0]);
      sy_q   <= 64'(uy[31:0]) * 64'(uy[31:0]);
      sat1_q <= (ux[UW-1:32] != '0) || (uy[UW-1:32] != '0);
      sq_q   <= sum[63:0];
      sat2_q <= sat1_q | sum[64];
    end
  end

  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  logic        sat_q  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic        sat_in;
    logic [35:0] cur, trial;

    if (j == 0) begin : g_first
      assign rad_in  = sq_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sat_in  = sat2_q;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign sat_in  = sat_q[j-1];
    end

    assign cur   = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j] <= {rad_in[61:0], 2'b00};
        sat_q[j] <= sat_in;
        if (cur >= trial) begin
          rem_q[j]  <= 34'(cur - trial);
          root_q[j] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[j]  <= 34'(cur);
          root_q[j] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];
  assign rem_o  = rem_q[SQRT_STEPS-1];
  assign sat_o  = sat_q[SQRT_STEPS-1];

endmodule

[design/segment_intersection_range_angle.sv]
// ----------------------------------------------------------------------------
// segment_intersection_range_angle
// Crossing of a beam segment P with a wall segment Q, with the crossing
// point, range from P's start and the acute incidence angle.
//
// in_i carries one segment pair per transfer, out_o one result per input.
// Results leave in input order. No crossing (parallel lines or a parameter
// outside [0,1]) gives hit 0 with all other fields 0.
// cfg_we_i/cfg_wdata_i write coincide_limit; write it only while the
// pipeline is empty.
// Throughput: one transfer per cycle when the receiver does not stall, fully pipelined.
// The lambda divider (one quotient bit per stage) and the 32-stage square
// root set the depth.
// Reset empties the pipeline and sets coincide_limit to 1.
// When the receiver stalls the whole pipeline holds; in_i.ready follows
// out_o.ready whenever the output register is full.
// ----------------------------------------------------------------------------
module segment_intersection_range_angle
  import sira_pkg::*;
#(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  sira_in_if.sink       in_i,
  sira_out_if.source    out_o
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // coordinate differences
  localparam int PW   = 2 * DW;         // first products
  localparam int EW   = PW + 1;         // den, nl, nm
  localparam int MBW  = DW + EW;        // nl * pd
  localparam int NW   = MBW + 1;        // divider numerator
  localparam int DVW  = EW + 1;         // divider denominator
  localparam int QW   = DW;             // quotient bits
  localparam int OW   = W + 2;          // offsets and crossing
  localparam int VW   = W + 3;          // angle vectors
  localparam int XW   = (OW > 32) ? OW : 32;
  localparam int LA   = 6 + CORDIC_STEPS;
  localparam int LR   = 2 + SQRT_STEPS;
  localparam int LMAX = (LA > LR) ? LA : LR;
  localparam int LTOT = 10 + QW + LMAX;

  logic en;
  logic [LTOT-1:0] v_q;
  logic [15:0] limit_q;

  assign en          = !v_q[LTOT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = v_q[LTOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      if (en) v_q <= {v_q[LTOT-2:0], in_i.valid};
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] pdx_q, pdy_q, qdx_q, qdy_q, wx_q, wy_q;
  logic signed [W-1:0]  psx_q, psy_q, qex_q, qey_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx_q <= DW'(in_i.p_end_x) - DW'(in_i.p_start_x);
      pdy_q <= DW'(in_i.p_end_y) - DW'(in_i.p_start_y);
      qdx_q <= DW'(in_i.q_end_x) - DW'(in_i.q_start_x);
      qdy_q <= DW'(in_i.q_end_y) - DW'(in_i.q_start_y);
      wx_q  <= DW'(in_i.q_start_x) - DW'(in_i.p_start_x);
      wy_q  <= DW'(in_i.q_start_y) - DW'(in_i.p_start_y);
      psx_q <= in_i.p_start_x;
      psy_q <= in_i.p_start_y;
      qex_q <= in_i.q_end_x;
      qey_q <= in_i.q_end_y;
    end
  end

  // stages 2-3: cross products
  logic signed [PW-1:0] pr0, pr1, pr2, pr3, pr4, pr5;

  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul0 (.clk_i, .en_i(en), .a_i(pdx_q), .b_i(qdy_q), .p_o(pr0));
  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul1 (.clk_i, .en_i(en), .a_i(pdy_q), .b_i(qdx_q), .p_o(pr1));
  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul2 (.clk_i, .en_i(en), .a_i(wx_q),  .b_i(qdy_q), .p_o(pr2));
  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul3 (.clk_i, .en_i(en), .a_i(wy_q),  .b_i(qdx_q), .p_o(pr3));
  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul4 (.clk_i, .en_i(en), .a_i(wx_q),  .b_i(pdy_q), .p_o(pr4));
  sira_mul #(.AWidth(DW), .BWidth(DW)) u_mul5 (.clk_i, .en_i(en), .a_i(wy_q),  .b_i(pdx_q), .p_o(pr5));

  // stage 4: determinants
  logic signed [EW-1:0] den_q, nl_q, nm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= EW'(pr0) - EW'(pr1);
      nl_q  <= EW'(pr2) - EW'(pr3);
      nm_q  <= EW'(pr4) - EW'(pr5);
    end
  end

  // stage 5: make den positive, check both parameters in [0,1]
  logic signed [EW-1:0] den_a, nl_a, nm_a, denf_q, nlf_q;
  logic                 hit5_q;

  assign den_a = den_q[EW-1] ? -den_q : den_q;
  assign nl_a  = den_q[EW-1] ? -nl_q  : nl_q;
  assign nm_a  = den_q[EW-1] ? -nm_q  : nm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      denf_q <= den_a;
      nlf_q  <= nl_a;
      hit5_q <= (den_q != '0) && !nl_a[EW-1] && (nl_a <= den_a) &&
                !nm_a[EW-1] && (nm_a <= den_a);
    end
  end

  logic [2*DW-1:0] pd5;
  logic signed [DW-1:0] pdx5, pdy5;

  sira_delay #(.Width(2*DW), .Depth(4)) u_dly_pd (
    .clk_i, .en_i(en), .d_i({pdx_q, pdy_q}), .q_o(pd5));
  assign pdx5 = $signed(pd5[2*DW-1:DW]);
  assign pdy5 = $signed(pd5[DW-1:0]);

  // stages 6-7: lambda numerators scaled by P direction
  logic signed [MBW-1:0] prx, pry;

  sira_mul #(.AWidth(DW), .BWidth(EW)) u_mulx (.clk_i, .en_i(en), .a_i(pdx5), .b_i(nlf_q), .p_o(prx));
  sira_mul #(.AWidth(DW), .BWidth(EW)) u_muly (.clk_i, .en_i(en), .a_i(pdy5), .b_i(nlf_q), .p_o(pry));

  logic [EW-1:0] den7;

  sira_delay #(.Width(EW), .Depth(2)) u_dly_den (
    .clk_i, .en_i(en), .d_i(denf_q), .q_o(den7));

  // stage 8: round-to-nearest setup, (2|n| + d) / 2d
  logic [NW-1:0]  nx_q, ny_q, abx, aby;
  logic [DVW-1:0] dv_q;
  logic           negx_q, negy_q;

  assign abx = prx[MBW-1] ? NW'(-prx) : NW'(prx);
  assign aby = pry[MBW-1] ? NW'(-pry) : NW'(pry);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= (abx << 1) + NW'(den7);
      ny_q   <= (aby << 1) + NW'(den7);
      dv_q   <= {den7, 1'b0};
      negx_q <= prx[MBW-1];
      negy_q <= pry[MBW-1];
    end
  end

  logic [QW-1:0] qx, qy;
  logic          tx, ty;

  sira_div #(.NumWidth(NW), .DenWidth(DVW), .QuoWidth(QW)) u_divx (
    .clk_i, .en_i(en), .num_i(nx_q), .den_i(dv_q), .tag_i(negx_q), .quo_o(qx), .tag_o(tx));
  sira_div #(.NumWidth(NW), .DenWidth(DVW), .QuoWidth(QW)) u_divy (
    .clk_i, .en_i(en), .num_i(ny_q), .den_i(dv_q), .tag_i(negy_q), .quo_o(qy), .tag_o(ty));

  logic [4*W-1:0] side;
  logic           hit_s;

  sira_delay #(.Width(4*W), .Depth(7 + QW)) u_dly_side (
    .clk_i, .en_i(en), .d_i({psx_q, psy_q, qex_q, qey_q}), .q_o(side));
  sira_delay #(.Width(1), .Depth(3 + QW)) u_dly_hit5 (
    .clk_i, .en_i(en), .d_i(hit5_q), .q_o(hit_s));

  // offsets and crossing point
  logic signed [OW-1:0] oxv, oyv, ox_q, oy_q, hx_q, hy_q;
  logic signed [W-1:0]  qexT_q, qeyT_q;
  logic                 hitT_q;

  assign oxv = tx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign oyv = ty ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q   <= oxv;
      oy_q   <= oyv;
      hx_q   <= OW'($signed(side[4*W-1:3*W])) + oxv;
      hy_q   <= OW'($signed(side[3*W-1:2*W])) + oyv;
      qexT_q <= $signed(side[2*W-1:W]);
      qeyT_q <= $signed(side[W-1:0]);
      hitT_q <= hit_s;
    end
  end

  // angle vectors: crossing to Q end, crossing to P start
  logic signed [VW-1:0] ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= VW'(qexT_q) - VW'(hx_q);
      ay_q <= VW'(qeyT_q) - VW'(hy_q);
      bx_q <= -VW'(ox_q);
      by_q <= -VW'(oy_q);
    end
  end

  logic [31:0] za, zb;

  sira_heading #(.Width(VW), .Steps(CORDIC_STEPS)) u_head_a (
    .clk_i, .en_i(en), .limit_i(limit_q), .x_i(ax_q), .y_i(ay_q), .z_o(za));
  sira_heading #(.Width(VW), .Steps(CORDIC_STEPS)) u_head_b (
    .clk_i, .en_i(en), .limit_i(limit_q), .x_i(bx_q), .y_i(by_q), .z_o(zb));

  // fold difference to a quarter turn, then scale to 1/256 degree
  logic [31:0] ang, ang_q;
  logic [47:0] angp_q, angp_d;

  always_comb begin
    ang = za - zb;
    if (ang >= ANG_HALF) ang = ang - ANG_HALF;
    if (ang > ANG_QUARTER) ang = ANG_HALF - ang;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q  <= ang;
      angp_q <= 48'(ang_q) * 48'(DEG_SCALE);
    end
  end

  sira_delay #(.Width(48), .Depth(LMAX - LA)) u_dly_ang (
    .clk_i, .en_i(en), .d_i(angp_q), .q_o(angp_d));

  // range
  logic [31:0] root, root_d;
  logic [33:0] rem, rem_d;
  logic        sat, sat_d;

  sira_range #(.Width(OW)) u_range (
    .clk_i, .en_i(en), .ox_i(ox_q), .oy_i(oy_q), .root_o(root), .rem_o(rem), .sat_o(sat));

  sira_delay #(.Width(67), .Depth(LMAX - LR)) u_dly_rng (
    .clk_i, .en_i(en), .d_i({root, rem, sat}), .q_o({root_d, rem_d, sat_d}));

  logic [2*OW:0]       pt_d;
  logic signed [XW-1:0] hxw, hyw;

  sira_delay #(.Width(2*OW+1), .Depth(LMAX)) u_dly_pt (
    .clk_i, .en_i(en), .d_i({hitT_q, hx_q, hy_q}), .q_o(pt_d));

  assign hxw = XW'($signed(pt_d[2*OW-1:OW]));
  assign hyw = XW'($signed(pt_d[OW-1:0]));

  // output register
  logic [32:0] rnd;
  logic [47:0] angr;
  logic [31:0] rng;
  logic        hit_q;
  logic signed [31:0] hitx_q, hity_q;
  logic [31:0] range_q;
  logic [14:0] inc_q;

  assign rnd  = (rem_d > {2'b00, root_d}) ? {1'b0, root_d} + 33'd1 : {1'b0, root_d};
  assign rng  = (sat_d || rnd[32]) ? OUT_MAX : rnd[31:0];
  assign angr = angp_d + ANG_ROUND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= pt_d[2*OW];
      hitx_q  <= pt_d[2*OW] ? hxw[31:0] : 32'sd0;
      hity_q  <= pt_d[2*OW] ? hyw[31:0] : 32'sd0;
      range_q <= pt_d[2*OW] ? rng : 32'd0;
      inc_q   <= pt_d[2*OW] ? angr[44:30] : 15'd0;
    end
  end

  assign out_o.hit       = hit_q;
  assign out_o.hit_x     = hitx_q;
  assign out_o.hit_y     = hity_q;
  assign out_o.range     = range_q;
  assign out_o.incidence = inc_q;

endmodule
